// ===== rtl/qes_pkg.sv =====
`default_nettype none
package qes_pkg;

  // Word format of the coefficients and roots.
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // Internal widths that follow from the word format.
  localparam int PROD_W   = 2 * WORD_BITS;
  localparam int DISC_W   = PROD_W + 1;
  localparam int SQ_STEPS = (DISC_W + 1) / 2;
  localparam int SQN_W    = 2 * SQ_STEPS;
  localparam int ROOT_W   = SQ_STEPS;
  localparam int SQREM_W  = ROOT_W + 3;
  localparam int NUM_W    = ROOT_W + 1;
  localparam int SNUM_W   = NUM_W + 1;
  localparam int DIVN_W   = NUM_W + FRAC_BITS;
  localparam int DEN_W    = WORD_BITS + 1;
  localparam int DREM_W   = DEN_W + 1;

  // Saturation limits for a positive and a negative root magnitude.
  localparam logic [DIVN_W-1:0] LIM_POS =
    {{(DIVN_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic [DIVN_W-1:0] LIM_NEG = LIM_POS + DIVN_W'(1);

  // Root-count codes.
  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_ONE  = 2'd1,
    CNT_TWO  = 2'd2,
    CNT_INF  = 2'd3
  } cnt_t;

  // Item information that travels alongside the square root pipeline.
  typedef struct packed {
    cnt_t                 count;
    logic                 linear;
    logic [WORD_BITS-1:0] amag;
    logic [WORD_BITS-1:0] bmag;
    logic [WORD_BITS-1:0] cmag;
    logic                 aneg;
    logic                 bneg;
    logic                 cneg;
  } sq_side_t;

  // Item information that travels alongside the divider pipeline.
  typedef struct packed {
    cnt_t count;
    logic neg1;
    logic neg2;
  } div_side_t;

  // Saturated root word and its overflow flag.
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 ovf;
  } sat_t;

  // Clamp a quotient magnitude to the word range and apply the sign.
  function automatic sat_t sat_root(input logic [DIVN_W-1:0] q, input logic neg);
    logic [DIVN_W-1:0]    lim;
    logic [WORD_BITS-1:0] mag;
    sat_t                 res;
    lim     = neg ? LIM_NEG : LIM_POS;
    res.ovf = (q > lim);
    mag     = res.ovf ? lim[WORD_BITS-1:0] : q[WORD_BITS-1:0];
    res.word = neg ? (~mag + WORD_BITS'(1)) : mag;
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/qes_front.sv =====
`default_nettype none
module qes_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [qes_pkg::WORD_BITS-1:0] coef_a,
  input  wire logic [qes_pkg::WORD_BITS-1:0] coef_b,
  input  wire logic [qes_pkg::WORD_BITS-1:0] coef_c,
  output logic                               out_valid,
  output logic [qes_pkg::DISC_W-1:0]         disc,
  output qes_pkg::sq_side_t                  side
);
  import qes_pkg::*;

  // Stage one: sign and magnitude of each coefficient.
  logic                 v1_r;
  logic [WORD_BITS-1:0] amag_r, bmag_r, cmag_r;
  logic                 aneg_r, bneg_r, cneg_r;

  // Stage two: the two products.
  logic                 v2_r;
  logic [PROD_W-1:0]    bsq_r, ac_r;
  logic [WORD_BITS-1:0] amag2_r, bmag2_r, cmag2_r;
  logic                 aneg2_r, bneg2_r, cneg2_r;

  // Stage three: classification and discriminant.
  logic                 v3_r;
  logic [DISC_W-1:0]    disc_r, disc_nxt;
  sq_side_t             side_r, side_nxt;

  logic [DISC_W-1:0]    bsq_w, ac4_w;
  logic                 add_mode, gt, eq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      aneg_r  <= coef_a[WORD_BITS-1];
      bneg_r  <= coef_b[WORD_BITS-1];
      cneg_r  <= coef_c[WORD_BITS-1];
      amag_r  <= coef_a[WORD_BITS-1] ? (~coef_a + WORD_BITS'(1)) : coef_a;
      bmag_r  <= coef_b[WORD_BITS-1] ? (~coef_b + WORD_BITS'(1)) : coef_b;
      cmag_r  <= coef_c[WORD_BITS-1] ? (~coef_c + WORD_BITS'(1)) : coef_c;
      bsq_r   <= PROD_W'(bmag_r) * PROD_W'(bmag_r);
      ac_r    <= PROD_W'(amag_r) * PROD_W'(cmag_r);
      amag2_r <= amag_r;
      bmag2_r <= bmag_r;
      cmag2_r <= cmag_r;
      aneg2_r <= aneg_r;
      bneg2_r <= bneg_r;
      cneg2_r <= cneg_r;
      disc_r  <= disc_nxt;
      side_r  <= side_nxt;
    end
  end

  // Opposite signs of a and c make 4ac negative, so the discriminant is a sum.
  always_comb begin
    bsq_w    = {1'b0, bsq_r};
    ac4_w    = {ac_r[PROD_W-2:0], 2'b00};
    add_mode = (cmag2_r != '0) && (aneg2_r != cneg2_r);
    gt       = (bsq_w > ac4_w);
    eq       = (bsq_w == ac4_w);
    if (add_mode) begin
      disc_nxt = bsq_w + ac4_w;
    end else if (gt) begin
      disc_nxt = bsq_w - ac4_w;
    end else begin
      disc_nxt = '0;
    end
    side_nxt.linear = (amag2_r == '0);
    side_nxt.amag   = amag2_r;
    side_nxt.bmag   = bmag2_r;
    side_nxt.cmag   = cmag2_r;
    side_nxt.aneg   = aneg2_r;
    side_nxt.bneg   = bneg2_r;
    side_nxt.cneg   = cneg2_r;
    if (amag2_r == '0) begin
      if (bmag2_r == '0) begin
        side_nxt.count = (cmag2_r == '0) ? CNT_INF : CNT_NONE;
      end else begin
        side_nxt.count = CNT_ONE;
      end
    end else if (add_mode || gt) begin
      side_nxt.count = CNT_TWO;
    end else if (eq) begin
      side_nxt.count = CNT_ONE;
    end else begin
      side_nxt.count = CNT_NONE;
    end
  end

  assign out_valid = v3_r;
  assign disc      = disc_r;
  assign side      = side_r;

endmodule
`default_nettype wire

// ===== rtl/qes_sqrt.sv =====
`default_nettype none
module qes_sqrt (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [qes_pkg::DISC_W-1:0] radicand,
  input  wire qes_pkg::sq_side_t         in_side,
  output logic                           out_valid,
  output logic [qes_pkg::ROOT_W-1:0]     root,
  output qes_pkg::sq_side_t              out_side
);
  import qes_pkg::*;

  // One result bit per stage, two radicand bits consumed per stage.
  logic                 v_r    [SQ_STEPS];
  logic [SQN_W-1:0]     n_r    [SQ_STEPS];
  logic [SQREM_W-1:0]   rem_r  [SQ_STEPS];
  logic [ROOT_W-1:0]    root_r [SQ_STEPS];
  sq_side_t             side_r [SQ_STEPS];

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_st
    logic               v_in;
    logic [SQN_W-1:0]   n_in;
    logic [SQREM_W-1:0] rem_in, rem_sh, trial;
    logic [ROOT_W-1:0]  root_in;
    sq_side_t           side_in;
    logic               ge;

    if (g == 0) begin : g_first
      always_comb begin
        v_in    = in_valid;
        n_in    = SQN_W'(radicand);
        rem_in  = '0;
        root_in = '0;
        side_in = in_side;
      end
    end else begin : g_next
      always_comb begin
        v_in    = v_r[g-1];
        n_in    = n_r[g-1];
        rem_in  = rem_r[g-1];
        root_in = root_r[g-1];
        side_in = side_r[g-1];
      end
    end

    // Restoring step: try appending a one bit to the partial root.
    always_comb begin
      rem_sh = {rem_in[SQREM_W-3:0], n_in[SQN_W-1 -: 2]};
      trial  = SQREM_W'({root_in, 2'b01});
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[g]    <= {n_in[SQN_W-3:0], 2'b00};
        rem_r[g]  <= ge ? (rem_sh - trial) : rem_sh;
        root_r[g] <= {root_in[ROOT_W-2:0], ge};
        side_r[g] <= side_in;
      end
    end
  end

  assign out_valid = v_r[SQ_STEPS-1];
  assign root      = root_r[SQ_STEPS-1];
  assign out_side  = side_r[SQ_STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/qes_div.sv =====
`default_nettype none
module qes_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [qes_pkg::DIVN_W-1:0] num1,
  input  wire logic [qes_pkg::DIVN_W-1:0] num2,
  input  wire logic [qes_pkg::DEN_W-1:0]  den,
  input  wire qes_pkg::div_side_t        in_side,
  output logic                           out_valid,
  output logic [qes_pkg::DIVN_W-1:0]     quot1,
  output logic [qes_pkg::DIVN_W-1:0]     quot2,
  output qes_pkg::div_side_t             out_side
);
  import qes_pkg::*;

  // Two lanes share one divisor; each stage yields one quotient bit per lane.
  // The numerator shifts out at the top while the quotient shifts in below.
  logic               v_r    [DIVN_W];
  logic [DIVN_W-1:0]  nq_r   [2][DIVN_W];
  logic [DEN_W-1:0]   rem_r  [2][DIVN_W];
  logic [DEN_W-1:0]   den_r  [DIVN_W];
  div_side_t          side_r [DIVN_W];

  for (genvar g = 0; g < DIVN_W; g++) begin : g_st
    logic              v_in;
    logic [DEN_W-1:0]  den_in;
    div_side_t         side_in;

    if (g == 0) begin : g_first
      always_comb begin
        v_in    = in_valid;
        den_in  = den;
        side_in = in_side;
      end
    end else begin : g_next
      always_comb begin
        v_in    = v_r[g-1];
        den_in  = den_r[g-1];
        side_in = side_r[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[g]  <= den_in;
        side_r[g] <= side_in;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DIVN_W-1:0] nq_in;
      logic [DEN_W-1:0]  rem_in;
      logic [DREM_W-1:0] rem_sh, rem_sub;
      logic              ge;

      if (g == 0) begin : g_first
        always_comb begin
          nq_in  = (l == 0) ? num1 : num2;
          rem_in = '0;
        end
      end else begin : g_next
        always_comb begin
          nq_in  = nq_r[l][g-1];
          rem_in = rem_r[l][g-1];
        end
      end

      // Restoring step: subtract the divisor when the partial remainder allows.
      always_comb begin
        rem_sh  = {rem_in, nq_in[DIVN_W-1]};
        ge      = (rem_sh >= {1'b0, den_in});
        rem_sub = rem_sh - {1'b0, den_in};
      end

      always_ff @(posedge clk) begin
        if (en) begin
          nq_r[l][g]  <= {nq_in[DIVN_W-2:0], ge};
          rem_r[l][g] <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
      end
    end
  end

  assign out_valid = v_r[DIVN_W-1];
  assign quot1     = nq_r[0][DIVN_W-1];
  assign quot2     = nq_r[1][DIVN_W-1];
  assign out_side  = side_r[DIVN_W-1];

endmodule
`default_nettype wire

// ===== rtl/quadratic_equation_solver_unit.sv =====
`default_nettype none
// Real-root solver for a*x^2 + b*x + c = 0 on signed Q16.16 coefficients. One
// coefficient triple is taken per clock while in_tready is high, and every result
// leaves in order: a front section classifies the equation and forms the exact
// discriminant, 33 pipeline stages take its integer square root one bit per
// stage, a register forms the numerators, 50 stages divide both roots one
// quotient bit per stage, and one output register holds the result. Throughput
// is one item per cycle; while out_tready is low with a result waiting, the
// whole pipeline holds and in_tready is low. The root count and the overflow
// flag travel in out_tuser, both roots in out_tdata; unused roots read zero.
module quadratic_equation_solver_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,   // coef_a [31:0], coef_b [63:32], coef_c [95:64]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // first_root [31:0], second_root [63:32]
  output logic [2:0]       out_tuser   // root_count [1:0], overflow [2]
);
  import qes_pkg::*;

  logic                 en;
  logic                 fr_valid, sq_valid, dv_valid;
  logic [DISC_W-1:0]    fr_disc;
  sq_side_t             fr_side, sq_side;
  logic [ROOT_W-1:0]    sq_root;
  logic [DIVN_W-1:0]    dv_q1, dv_q2;
  div_side_t            dv_side;

  // Numerator preparation stage.
  logic                 prep_v_r;
  logic [DIVN_W-1:0]    num1_r, num2_r, num1_nxt, num2_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  div_side_t            dside_r, dside_nxt;

  logic [SNUM_W-1:0]    nb, s_ext, sn1, sn2;
  logic [NUM_W-1:0]     mag1, mag2;
  logic                 dneg, nneg1;

  // Output register.
  logic                 out_v_r;
  logic [WORD_BITS-1:0] r1_r, r2_r, r1_nxt, r2_nxt;
  cnt_t                 cnt_r;
  logic                 ovf_r, ovf_nxt;
  sat_t                 s1, s2;

  // The pipeline advances unless a finished result is waiting to be taken.
  assign en        = !out_v_r || out_tready;
  assign in_tready = en;

  qes_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .coef_a    (in_tdata[31:0]),
    .coef_b    (in_tdata[63:32]),
    .coef_c    (in_tdata[95:64]),
    .out_valid (fr_valid),
    .disc      (fr_disc),
    .side      (fr_side)
  );

  qes_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .radicand  (fr_disc),
    .in_side   (fr_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  // Signed numerators -b + s and -b - s, or -c for the linear equation.
  always_comb begin
    nb    = sq_side.bneg ? SNUM_W'(sq_side.bmag) : (~SNUM_W'(sq_side.bmag) + SNUM_W'(1));
    s_ext = SNUM_W'(sq_root);
    sn1   = nb + s_ext;
    sn2   = nb - s_ext;
    if (sq_side.linear) begin
      mag1    = NUM_W'(sq_side.cmag);
      nneg1   = !sq_side.cneg && (sq_side.cmag != '0);
      den_nxt = DEN_W'(sq_side.bmag);
      dneg    = sq_side.bneg;
    end else begin
      mag1    = sn1[SNUM_W-1] ? NUM_W'(~sn1 + SNUM_W'(1)) : NUM_W'(sn1);
      nneg1   = sn1[SNUM_W-1];
      den_nxt = {sq_side.amag, 1'b0};
      dneg    = sq_side.aneg;
    end
    mag2            = sn2[SNUM_W-1] ? NUM_W'(~sn2 + SNUM_W'(1)) : NUM_W'(sn2);
    num1_nxt        = {mag1, {FRAC_BITS{1'b0}}};
    num2_nxt        = {mag2, {FRAC_BITS{1'b0}}};
    dside_nxt.count = sq_side.count;
    dside_nxt.neg1  = nneg1 ^ dneg;
    dside_nxt.neg2  = sn2[SNUM_W-1] ^ dneg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else if (en) begin
      prep_v_r <= sq_valid;
      out_v_r  <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num1_r  <= num1_nxt;
      num2_r  <= num2_nxt;
      den_r   <= den_nxt;
      dside_r <= dside_nxt;
      r1_r    <= r1_nxt;
      r2_r    <= r2_nxt;
      cnt_r   <= dv_side.count;
      ovf_r   <= ovf_nxt;
    end
  end

  qes_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (prep_v_r),
    .num1      (num1_r),
    .num2      (num2_r),
    .den       (den_r),
    .in_side   (dside_r),
    .out_valid (dv_valid),
    .quot1     (dv_q1),
    .quot2     (dv_q2),
    .out_side  (dv_side)
  );

  // Saturate the quotients and keep only the roots the count calls for.
  always_comb begin
    s1 = sat_root(dv_q1, dv_side.neg1);
    s2 = sat_root(dv_q2, dv_side.neg2);
    case (dv_side.count)
      CNT_ONE: begin
        r1_nxt  = s1.word;
        r2_nxt  = '0;
        ovf_nxt = s1.ovf;
      end
      CNT_TWO: begin
        r1_nxt  = s1.word;
        r2_nxt  = s2.word;
        ovf_nxt = s1.ovf || s2.ovf;
      end
      default: begin
        r1_nxt  = '0;
        r2_nxt  = '0;
        ovf_nxt = 1'b0;
      end
    endcase
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {r2_r, r1_r};
  assign out_tuser  = {ovf_r, cnt_r};

endmodule
`default_nettype wire

// ===== rtl/qes_checker.sv =====
`default_nettype none
module qes_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [2:0]  out_tuser
);
  import qes_pkg::*;

  // A result held back by the sink must stay unchanged.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Input is taken exactly when the output stage can move.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  // Without a finite root both root words are zero and no overflow is raised.
  a_noroot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == CNT_NONE || out_tuser[1:0] == CNT_INF)
      |-> out_tdata == '0 && !out_tuser[2])
    else $error("root reported for an equation without finite roots");

  // A single root leaves the second root word clear.
  a_oneroot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == CNT_ONE |-> out_tdata[63:32] == '0)
    else $error("second root set for a single-root result");

  // Nothing leaves the block in the cycle after reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

endmodule

bind quadratic_equation_solver_unit qes_checker u_qes_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
